// ===== rtl/lru_key_value_cache_macros.svh =====
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LKV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lru cache assertion failed");
// Next-cycle implication.
`define LKV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lru cache assertion failed");
`else
`define LKV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LKV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 4;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;
	localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic cmp_en;
		logic upd_en;
		logic hit;
		logic put;
		logic evict;
	} lkv_cell_ctl_t;

endpackage

// ===== rtl/lkv_req_if.sv =====
interface lkv_req_if;
	import lkv_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [KEY_W-1:0]  key;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, output func, output key, output value, input ready);
	modport sink (input valid, input func, input key, input value, output ready);
endinterface

// ===== rtl/lkv_rsp_if.sv =====
interface lkv_rsp_if;
	import lkv_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [VAL_W-1:0]  read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/lkv_cell.sv =====
module lkv_cell #(
	parameter int IDX = 0,
	parameter int RW  = 3,
	parameter int CW  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkv_pkg::lkv_cell_ctl_t ctl,
	input  logic [lkv_pkg::KEY_W-1:0] key,
	input  logic [lkv_pkg::VAL_W-1:0] value,
	input  logic [CW-1:0]         old_rank,
	input  logic [CW-1:0]         fill,
	output logic                  match,
	output logic                  valid,
	output logic [lkv_pkg::VAL_W-1:0] match_value,
	output logic [RW-1:0]         match_rank
);
	import lkv_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic [RW-1:0]    rank_q;
	logic             valid_q;
	logic             match_q;
	logic [CW-1:0]    rank_ext;
	logic             sel;
	logic             age;
	logic             touch;
	logic             is_new;

	assign rank_ext = CW'(rank_q);
	assign is_new   = ctl.put && !ctl.hit;
	assign touch    = ctl.upd_en && (ctl.hit || ctl.put);

	always_comb begin
		priority if (ctl.hit) begin
			sel = match_q;
		end else if (is_new && ctl.evict) begin
			// victim is the valid entry whose age equals the oldest rank
			sel = valid_q && (rank_ext == old_rank);
		end else if (is_new) begin
			// valid entries always occupy a prefix, so the free slot is at fill
			sel = (fill == MY_IDX);
		end else begin
			sel = 1'b0;
		end
	end

	assign age = valid_q && !sel && (rank_ext < old_rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp_en) begin
				match_q <= valid_q && (key_q == key);
			end
			if (touch) begin
				if (sel) begin
					rank_q  <= '0;
					valid_q <= 1'b1;
				end else if (age) begin
					rank_q <= rank_q + RW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (touch && sel && ctl.put) begin
			value_q <= value;
			if (is_new) begin
				key_q <= key;
			end
		end
	end

	assign match       = match_q;
	assign valid       = valid_q;
	assign match_value = match_q ? value_q : '0;
	assign match_rank  = match_q ? rank_q : '0;
endmodule

// ===== rtl/lru_key_value_cache.sv =====
// A request passes the compare state, where the key compare is registered in
// the cells, then the update state, where the recency update and result write
// happen and the result is registered.
// A held result stalls the update stage; the next request is taken as it leaves.
// Reset clears all valid marks, ranks and the fill count, sets the capacity to 8
// and empties the result register.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
	parameter int MAX_ENTRIES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lkv_req_if.sink                      req,
	lkv_rsp_if.source                    rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0]    cfg_active_capacity
);
	import lkv_pkg::*;

	localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} lkv_state_t;

	lkv_state_t       state_q;
	logic             req_func_q;
	logic [KEY_W-1:0] req_key_q;
	logic [VAL_W-1:0] req_value_q;
	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    fill_q;
	logic             out_valid_q;
	logic             out_hit_q;
	logic [VAL_W-1:0] out_value_q;

	logic             fire_upd;
	logic             in_xfer;
	logic [CAPW-1:0]  cap_eff;
	logic             full;
	logic             hit;
	logic [VAL_W-1:0] hit_value;
	logic [RW-1:0]    hit_rank;
	logic [CW-1:0]    old_rank;
	lkv_cell_ctl_t    ctl;

	logic [MAX_ENTRIES-1:0] match_vec;
	logic [MAX_ENTRIES-1:0] valid_vec;
	logic [VAL_W-1:0]       cell_value [MAX_ENTRIES];
	logic [RW-1:0]          cell_rank  [MAX_ENTRIES];

	assign cfg_ready = 1'b1;

	assign fire_upd  = (state_q == ST_UPD) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE) || fire_upd;
	assign in_xfer   = req.valid && req.ready;

	always_comb begin
		cap_eff = CAPW'(cap_q);
		if (cap_q == '0) begin
			cap_eff = CAPW'(1);
		end else if (CAPW'(cap_q) > CAPW'(MAX_ENTRIES)) begin
			cap_eff = CAPW'(MAX_ENTRIES);
		end
	end

	assign full = CAPW'(fill_q) >= cap_eff;

	assign hit = |match_vec;

	// At most one cell matches, so an OR over masked outputs selects it.
	always_comb begin
		hit_value = '0;
		hit_rank  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_value = hit_value | cell_value[i];
			hit_rank  = hit_rank | cell_rank[i];
		end
	end

	always_comb begin
		priority if (hit) begin
			old_rank = CW'(hit_rank);
		end else if (full) begin
			old_rank = fill_q - CW'(1);
		end else begin
			old_rank = fill_q;
		end
	end

	assign ctl.cmp_en = (state_q == ST_CMP);
	assign ctl.upd_en = fire_upd;
	assign ctl.hit    = hit;
	assign ctl.put    = (req_func_q == FUNC_PUT);
	assign ctl.evict  = (req_func_q == FUNC_PUT) && !hit && full;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		lkv_cell #(
			.IDX (g),
			.RW  (RW),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.key         (req_key_q),
			.value       (req_value_q),
			.old_rank    (old_rank),
			.fill        (fill_q),
			.match       (match_vec[g]),
			.valid       (valid_vec[g]),
			.match_value (cell_value[g]),
			.match_rank  (cell_rank[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_active_capacity;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (in_xfer) begin
						state_q <= ST_CMP;
					end else if (fire_upd) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fire_upd && ctl.put && !hit && !full) begin
				fill_q <= fill_q + CW'(1);
			end

			if (fire_upd) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_func_q  <= req.func;
			req_key_q   <= req.key;
			req_value_q <= req.value;
		end
		if (fire_upd) begin
			out_hit_q <= hit;
			if (req_func_q == FUNC_PUT) begin
				out_value_q <= req_value_q;
			end else if (hit) begin
				out_value_q <= hit_value;
			end else begin
				out_value_q <= MISS_VALUE;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.read_value = out_value_q;

	`LKV_ASSERT_IMP(a_one_match, clk, arst_n, state_q == ST_UPD, $onehot0(match_vec))
	`LKV_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(MAX_ENTRIES))
	`LKV_ASSERT_IMP(a_fill_valid, clk, arst_n, 1'b1, $countones(valid_vec) == fill_q)
	`LKV_ASSERT_NXT(a_upd_result, clk, arst_n, fire_upd, out_valid_q)
endmodule
